@@ hw/rtl/assert_macros.svh @@
// Concurrent assertion macros shared by the RTL.
// No dependencies; take in by include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, off while reset is asserted.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed: lbl");

// Check that an expression never holds on the rising clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: lbl");

`endif

@@ hw/rtl/dt64_pkg.sv @@
// Shared types, constants and the counter step function for the dual timer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dt64_pkg;
	localparam int TIMER_INSTANCES = 2;
	localparam int COMPARE_COUNT   = 8;
	localparam int EVT_BITS        = 10;

	localparam logic [31:0] BASE_FIRST  = 32'd29491200;
	localparam logic [31:0] BASE_SECOND = 32'd29495296;
	localparam logic [1:0][31:0] TIMER_BASE = {BASE_SECOND, BASE_FIRST};

	localparam logic [31:0] REVISION_WORD = 32'h4472020c;
	localparam logic [31:0] TCR_WMASK     = 32'h04c03ffe;
	localparam logic [31:0] TGCR_WMASK    = 32'h0000ff1f;
	localparam logic [31:0] GPEN_WMASK    = 32'h00030033;
	localparam logic [31:0] GPDIR_WMASK   = 32'h00030003;
	localparam logic [31:0] ICS_ENABLES   = 32'h00050005;
	localparam logic [31:0] ICS_STATUS    = 32'h000a000a;
	localparam logic [31:0] WDT_WMASK     = 32'hffff4000;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;

	localparam logic [1:0] MODE_64    = 2'd0;
	localparam logic [1:0] MODE_UNCH  = 2'd1;
	localparam logic [1:0] MODE_WDT   = 2'd2;
	localparam logic [1:0] MODE_CHAIN = 2'd3;

	localparam logic [1:0] ENA_OFF     = 2'd0;
	localparam logic [1:0] ENA_ONESHOT = 2'd1;
	localparam logic [1:0] ENA_RELOAD  = 2'd3;

	localparam logic [3:0] SIZE_WORD = 4'd4;

	localparam logic [11:0] OFF_REV   = 12'h000;
	localparam logic [11:0] OFF_EMU   = 12'h004;
	localparam logic [11:0] OFF_GPEN  = 12'h008;
	localparam logic [11:0] OFF_GPDIR = 12'h00c;
	localparam logic [11:0] OFF_CNTLO = 12'h010;
	localparam logic [11:0] OFF_CNTHI = 12'h014;
	localparam logic [11:0] OFF_PRDLO = 12'h018;
	localparam logic [11:0] OFF_PRDHI = 12'h01c;
	localparam logic [11:0] OFF_TCR   = 12'h020;
	localparam logic [11:0] OFF_TGCR  = 12'h024;
	localparam logic [11:0] OFF_WDT   = 12'h028;
	localparam logic [11:0] OFF_RELLO = 12'h034;
	localparam logic [11:0] OFF_RELHI = 12'h038;
	localparam logic [11:0] OFF_CAPLO = 12'h03c;
	localparam logic [11:0] OFF_CAPHI = 12'h040;
	localparam logic [11:0] OFF_ICS   = 12'h044;
	localparam logic [11:0] OFF_CMP0  = 12'h060;
	localparam logic [11:0] OFF_CMPN  = OFF_CMP0 + 12'(4 * (COMPARE_COUNT - 1));

	typedef struct packed {
		logic        tick;
		logic        rd;
		logic        wr;
		logic [11:0] off;
		logic [31:0] wdata;
	} dt64_cmd_t;

	typedef struct packed {
		logic [31:0]         rdata;
		logic                rd_known;
		logic                wr_known;
		logic [EVT_BITS-1:0] hits;
	} dt64_rsp_t;

	typedef struct packed {
		logic [63:0] cnt;
		logic [63:0] prd;
		logic        hit;
	} dt64_step_t;

	function automatic dt64_step_t count_step(input logic [63:0] cnt, input logic [63:0] prd,
			input logic [63:0] rel, input logic [1:0] ena);
		dt64_step_t r;
		r.cnt = cnt;
		r.prd = prd;
		r.hit = 1'b0;
		if (ena != ENA_OFF && prd != 64'd0) begin
			if (cnt == prd) begin
				if (ena != ENA_ONESHOT) begin
					r.cnt = 64'd0;
					if (ena == ENA_RELOAD)
						r.prd = rel;
				end
			end else begin
				r.cnt = cnt + 64'd1;
				r.hit = (r.cnt == prd);
			end
		end
		return r;
	endfunction
endpackage
`default_nettype wire

@@ hw/rtl/dt64_timer.sv @@
// One timer instance: register file, tick logic, read side effects and writes.
// Depends on dt64_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dt64_timer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dt64_pkg::dt64_cmd_t cmd,
	output dt64_pkg::dt64_rsp_t    rsp
);
	import dt64_pkg::*;

	logic [31:0] cnt_lo_q, cnt_hi_q, prd_lo_q, prd_hi_q, rel_lo_q, rel_hi_q;
	logic [31:0] cap_lo_q, cap_hi_q, tcr_q, tgcr_q, ics_q, gpen_q, gpdir_q, wdt_q;
	logic [31:0] shadow_q;
	logic        shadow_vld_q;
	logic [1:0]  emu_q;
	logic [COMPARE_COUNT-1:0][31:0] cmp_q;

	logic [31:0] cnt_lo_d, cnt_hi_d, prd_lo_d, prd_hi_d, rel_lo_d, rel_hi_d;
	logic [31:0] cap_lo_d, cap_hi_d, tcr_d, tgcr_d, ics_d, gpen_d, gpdir_d, wdt_d;
	logic [31:0] shadow_d;
	logic        shadow_vld_d;
	logic [1:0]  emu_d;
	logic [COMPARE_COUNT-1:0][31:0] cmp_d;

	logic [1:0] mode, ena12, ena34;
	logic       clk12, rr_lo, rr_hi, cmp_sel;
	logic [2:0] cmp_idx;

	assign mode    = tgcr_q[3:2];
	assign ena12   = tcr_q[7:6];
	assign ena34   = tcr_q[23:22];
	assign clk12   = (tcr_q[9:8] == 2'b00);
	assign rr_lo   = tgcr_q[4] && mode == MODE_UNCH && tcr_q[10];
	assign rr_hi   = tgcr_q[4] && mode == MODE_UNCH && tcr_q[26];
	assign cmp_sel = cmd.off inside {[OFF_CMP0:OFF_CMPN]};
	assign cmp_idx = cmd.off[4:2];

	always_comb begin
		dt64_step_t  st;
		logic [31:0] cnt_lo_prev;
		logic [3:0]  phase;
		logic [EVT_BITS-1:0] h;
		logic [31:0] w;
		cnt_lo_d = cnt_lo_q; cnt_hi_d = cnt_hi_q; prd_lo_d = prd_lo_q; prd_hi_d = prd_hi_q;
		rel_lo_d = rel_lo_q; rel_hi_d = rel_hi_q; cap_lo_d = cap_lo_q; cap_hi_d = cap_hi_q;
		tcr_d = tcr_q; tgcr_d = tgcr_q; ics_d = ics_q; gpen_d = gpen_q; gpdir_d = gpdir_q;
		wdt_d = wdt_q; shadow_d = shadow_q; shadow_vld_d = shadow_vld_q; emu_d = emu_q;
		cmp_d = cmp_q;
		h = '0;
		w = cmd.wdata;
		cnt_lo_prev = cnt_lo_q;
		phase = tgcr_q[15:12];
		st = '0;
		rsp.rdata = '0;
		rsp.rd_known = 1'b1;
		rsp.wr_known = 1'b1;
		case (cmd.off)
			OFF_REV: rsp.wr_known = 1'b0;
			OFF_EMU, OFF_GPEN, OFF_GPDIR, OFF_CNTLO, OFF_CNTHI, OFF_PRDLO, OFF_PRDHI,
			OFF_TCR, OFF_TGCR, OFF_WDT, OFF_RELLO, OFF_RELHI, OFF_CAPLO, OFF_CAPHI,
			OFF_ICS: ;
			default: begin
				rsp.rd_known = cmp_sel;
				rsp.wr_known = cmp_sel;
			end
		endcase

		if (cmd.tick && tgcr_q[1:0] != 2'b00) begin
			if (mode == MODE_UNCH) begin
				if (tgcr_q[0] && clk12) begin
					st = count_step({32'd0, cnt_lo_q}, {32'd0, prd_lo_q}, {32'd0, rel_lo_q}, ena12);
					h[0] = st.hit;
					cnt_lo_d = st.cnt[31:0];
					prd_lo_d = st.prd[31:0];
					if (cnt_lo_d != cnt_lo_prev && tgcr_q[4]) begin
						for (int n = 0; n < COMPARE_COUNT; n++)
							h[2+n] = (cmp_q[n] != 32'd0) && (cmp_q[n] == cnt_lo_d);
					end
				end
				if (tgcr_q[1] && ena34 != ENA_OFF) begin
					if (phase == tgcr_q[11:8]) begin
						tgcr_d[15:12] = 4'd0;
						st = count_step({32'd0, cnt_hi_q}, {32'd0, prd_hi_q}, {32'd0, rel_hi_q},
							ena34);
						h[1] = st.hit;
						cnt_hi_d = st.cnt[31:0];
						prd_hi_d = st.prd[31:0];
					end else begin
						tgcr_d[15:12] = phase + 4'd1;
					end
				end
			end else if (mode != MODE_WDT && tgcr_q[1:0] == 2'b11 && clk12 &&
					ena12 != ENA_OFF) begin
				if (mode == MODE_CHAIN) begin
					if (cnt_hi_q == prd_hi_q) begin
						cnt_hi_d = 32'd0;
						st = count_step({32'd0, cnt_lo_q}, {32'd0, prd_lo_q}, {32'd0, rel_lo_q},
							ena12);
						h[0] = st.hit;
						cnt_lo_d = st.cnt[31:0];
						prd_lo_d = st.prd[31:0];
						if (ena12 == ENA_RELOAD && prd_lo_q != 32'd0 && cnt_lo_q == prd_lo_q)
							prd_hi_d = rel_hi_q;
					end else begin
						cnt_hi_d = cnt_hi_q + 32'd1;
					end
				end else begin
					st = count_step({cnt_hi_q, cnt_lo_q}, {prd_hi_q, prd_lo_q},
						{rel_hi_q, rel_lo_q}, ena12);
					h[0] = st.hit;
					{cnt_hi_d, cnt_lo_d} = st.cnt;
					{prd_hi_d, prd_lo_d} = st.prd;
				end
			end
			if (h[0]) begin
				ics_d[1] = 1'b1;
				h[0] = ics_q[0];
			end
			if (h[1]) begin
				ics_d[17] = 1'b1;
				h[1] = ics_q[16];
			end
		end

		if (cmd.rd && rsp.rd_known) begin
			case (cmd.off)
				OFF_REV:   rsp.rdata = REVISION_WORD;
				OFF_EMU:   rsp.rdata = {30'd0, emu_q};
				OFF_GPEN:  rsp.rdata = gpen_q;
				OFF_GPDIR: rsp.rdata = gpdir_q;
				OFF_CNTLO: begin
					rsp.rdata = cnt_lo_q;
					if (mode == MODE_64) begin
						shadow_d = cnt_hi_q;
						shadow_vld_d = 1'b1;
					end else if (rr_lo) begin
						cap_lo_d = cnt_lo_q;
						if (ena12 == ENA_RELOAD)
							prd_lo_d = rel_lo_q;
						cnt_lo_d = 32'd0;
					end
				end
				OFF_CNTHI: begin
					rsp.rdata = shadow_vld_q ? shadow_q : cnt_hi_q;
					shadow_vld_d = 1'b0;
					if (rr_hi) begin
						cap_hi_d = cnt_hi_q;
						if (ena34 == ENA_RELOAD)
							prd_hi_d = rel_hi_q;
						cnt_hi_d = 32'd0;
					end
				end
				OFF_PRDLO: rsp.rdata = prd_lo_q;
				OFF_PRDHI: rsp.rdata = prd_hi_q;
				OFF_TCR:   rsp.rdata = tcr_q;
				OFF_TGCR:  rsp.rdata = tgcr_q;
				OFF_WDT:   rsp.rdata = wdt_q;
				OFF_RELLO: rsp.rdata = rel_lo_q;
				OFF_RELHI: rsp.rdata = rel_hi_q;
				OFF_CAPLO: rsp.rdata = cap_lo_q;
				OFF_CAPHI: rsp.rdata = cap_hi_q;
				OFF_ICS:   rsp.rdata = ics_q;
				default:   rsp.rdata = cmp_q[cmp_idx];
			endcase
		end

		if (cmd.wr && rsp.wr_known) begin
			case (cmd.off)
				OFF_EMU:   emu_d = w[1:0];
				OFF_GPEN:  gpen_d = w & GPEN_WMASK;
				OFF_GPDIR: gpdir_d = w & GPDIR_WMASK;
				OFF_CNTLO: cnt_lo_d = w;
				OFF_CNTHI: begin
					cnt_hi_d = w;
					shadow_vld_d = 1'b0;
				end
				OFF_PRDLO: prd_lo_d = w;
				OFF_PRDHI: prd_hi_d = w;
				OFF_TCR:   tcr_d = w & TCR_WMASK;
				OFF_TGCR: begin
					tgcr_d = w & TGCR_WMASK;
					if (tgcr_d[3:2] != MODE_64)
						shadow_vld_d = 1'b0;
					if (!tgcr_d[0])
						cnt_lo_d = 32'd0;
					if (!tgcr_d[1]) begin
						cnt_hi_d = 32'd0;
						shadow_vld_d = 1'b0;
					end
				end
				OFF_WDT: begin
					wdt_d = w & WDT_WMASK;
					wdt_d[15] = w[15] ? 1'b0 : wdt_q[15];
				end
				OFF_RELLO: rel_lo_d = w;
				OFF_RELHI: rel_hi_d = w;
				OFF_CAPLO: cap_lo_d = w;
				OFF_CAPHI: cap_hi_d = w;
				OFF_ICS:   ics_d = (ics_q & ICS_STATUS & ~(w & ICS_STATUS)) | (w & ICS_ENABLES);
				default:   cmp_d[cmp_idx] = w;
			endcase
		end
		rsp.hits = h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_lo_q <= '0; cnt_hi_q <= '0; prd_lo_q <= '0; prd_hi_q <= '0;
			rel_lo_q <= '0; rel_hi_q <= '0; cap_lo_q <= '0; cap_hi_q <= '0;
			tcr_q <= '0; tgcr_q <= '0; ics_q <= '0; gpen_q <= '0; gpdir_q <= '0;
			wdt_q <= '0; shadow_q <= '0; shadow_vld_q <= 1'b0; emu_q <= '0;
			cmp_q <= '0;
		end else begin
			cnt_lo_q <= cnt_lo_d; cnt_hi_q <= cnt_hi_d; prd_lo_q <= prd_lo_d;
			prd_hi_q <= prd_hi_d; rel_lo_q <= rel_lo_d; rel_hi_q <= rel_hi_d;
			cap_lo_q <= cap_lo_d; cap_hi_q <= cap_hi_d; tcr_q <= tcr_d; tgcr_q <= tgcr_d;
			ics_q <= ics_d; gpen_q <= gpen_d; gpdir_q <= gpdir_d; wdt_q <= wdt_d;
			shadow_q <= shadow_d; shadow_vld_q <= shadow_vld_d; emu_q <= emu_d;
			cmp_q <= cmp_d;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/dual_timer64_register_block.sv @@
// Path: input transaction to result through the input register, then the result register.
// Throughput: one transaction per cycle while m_tready does not stall; timer state updates
// in the cycle the item leaves the input register, so each item sees all earlier ones.
// Reset: arst_n clears all timer registers and both stage valid flags at once.
// Depends on dt64_pkg, dt64_timer and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
module dual_timer64_register_block (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // address, write_data, access_size, commit, zero pad
	input  wire logic [1:0]  s_tuser,  // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata   // read_data, access_ok, event_bits, zero pad
);
	import dt64_pkg::*;
	`include "assert_macros.svh"

	logic        vld_s1, commit_s1;
	logic [1:0]  act_s1;
	logic [31:0] addr_s1;
	logic [32:0] wd_s1;
	logic [3:0]  size_s1;

	logic        res_vld_q, res_ok_q;
	logic [31:0] res_rdata_q;
	logic [19:0] res_evt_q;

	logic        advance, fire, aligned, wr_legal, ok, is_tick;
	logic [11:0] off;
	logic [31:0] rdata;
	logic [19:0] evt;
	logic [TIMER_INSTANCES-1:0] sel;
	dt64_cmd_t cmd [TIMER_INSTANCES];
	dt64_rsp_t rsp [TIMER_INSTANCES];

	assign advance  = !res_vld_q || m_tready;
	assign s_tready = !vld_s1 || advance;
	assign fire     = vld_s1 && advance;
	assign off      = addr_s1[11:0];
	assign aligned  = (off[1:0] == 2'b00);
	assign wr_legal = aligned && size_s1 == SIZE_WORD && !wd_s1[32] && off != OFF_REV;
	assign is_tick  = act_s1 == ACT_TICK;

	always_comb begin
		logic taken;
		taken = 1'b0;
		for (int i = 0; i < TIMER_INSTANCES; i++) begin
			sel[i] = !taken && addr_s1[31:12] == TIMER_BASE[i][31:12];
			taken  = taken || sel[i];
		end
	end

	for (genvar i = 0; i < TIMER_INSTANCES; i++) begin : g_timer
		assign cmd[i].tick  = fire && is_tick;
		assign cmd[i].rd    = fire && act_s1 == ACT_READ && sel[i] && aligned;
		assign cmd[i].wr    = fire && act_s1 == ACT_WRITE && sel[i] && wr_legal && commit_s1;
		assign cmd[i].off   = off;
		assign cmd[i].wdata = wd_s1[31:0];
		dt64_timer u_timer (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[i]),
			.rsp    (rsp[i])
		);
	end

	always_comb begin
		rdata = '0;
		evt   = '0;
		ok    = 1'b0;
		for (int i = 0; i < TIMER_INSTANCES; i++) begin
			evt[i*EVT_BITS +: EVT_BITS] = rsp[i].hits;
			if (sel[i]) begin
				rdata = rsp[i].rdata;
				case (act_s1)
					ACT_READ:  ok = aligned && rsp[i].rd_known;
					ACT_WRITE: ok = wr_legal && rsp[i].wr_known;
					default:   ok = 1'b0;
				endcase
			end
		end
		if (is_tick)
			ok = 1'b1;
		else
			evt = '0;
		if (act_s1 != ACT_READ || !ok)
			rdata = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			addr_s1   <= s_tdata[31:0];
			wd_s1     <= s_tdata[64:32];
			size_s1   <= s_tdata[68:65];
			commit_s1 <= s_tdata[69];
			act_s1    <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (fire) begin
			res_vld_q <= 1'b1;
		end else if (m_tready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_rdata_q <= rdata;
			res_ok_q    <= ok;
			res_evt_q   <= evt;
		end
	end

	assign m_tvalid = res_vld_q;
	assign m_tdata  = {3'd0, res_evt_q, res_ok_q, res_rdata_q};

	`ASSERT_PROP(a_fire_loads, clk, arst_n, fire |=> res_vld_q)
	`ASSERT_NEVER(a_data_without_ok, clk, arst_n, res_vld_q && res_rdata_q != 32'd0 && !res_ok_q)
	`ASSERT_PROP(a_tick_ok, clk, arst_n, fire && is_tick |=> res_ok_q)
endmodule
`default_nettype wire

@@ verif/dual_timer64_register_block_tb.sv @@
// Self-checking testbench for dual_timer64_register_block: ticks, reads and writes
// are checked against a cycle-free predictor of both timers. Depends on dt64_pkg.
`timescale 1ns / 1ps
module dual_timer64_register_block_tb;
	import dt64_pkg::*;

	typedef struct {
		logic [1:0]  action;
		logic [31:0] addr;
		logic [32:0] wdata;
		logic [3:0]  size;
		logic        commit;
		bit          drain;
	} bus_item_t;

	typedef struct {
		logic [31:0] rdata;
		logic        ok;
		logic [19:0] events;
	} bus_result_t;

	localparam logic [1:0] ACT_BAD = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic [1:0]  s_tuser = ACT_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;

	bus_item_t   pending_items[$];
	bus_result_t expected_results[$];
	int          errors = 0;
	int          gap = 0;
	int          results_seen = 0;
	int          hold_cycles = 0;
	bit          hold_done = 0;

	logic [31:0] cnt_lo[2], cnt_hi[2], prd_lo[2], prd_hi[2], rel_lo[2], rel_hi[2];
	logic [31:0] cap_lo[2], cap_hi[2], tcr[2], gcr[2], ics[2], cmp[2][8];
	logic [31:0] emu[2], gpen[2], gpdir[2], wdt[2], shadow_hi[2];
	bit          shadow_ok[2];

	dual_timer64_register_block i_dut (.*);

	always #1 clk = ~clk;

	function automatic bit counter_advance(inout logic [63:0] c, inout logic [63:0] p,
			input logic [63:0] r, input logic [1:0] ena);
		if (ena == ENA_OFF || p == 64'd0)
			return 0;
		if (c == p) begin
			if (ena != ENA_ONESHOT) begin
				c = 64'd0;
				if (ena == ENA_RELOAD)
					p = r;
			end
			return 0;
		end
		c = c + 64'd1;
		return c == p;
	endfunction

	function automatic logic [9:0] timer_tick(int t);
		logic [1:0]  mode, ena12, ena34;
		logic [9:0]  hits;
		logic [63:0] c, p;
		logic [31:0] prior;
		bit          clk12, both;
		mode = gcr[t][3:2];
		ena12 = tcr[t][7:6];
		ena34 = tcr[t][23:22];
		clk12 = tcr[t][9:8] == 2'b00;
		hits = '0;
		if (mode == MODE_WDT)
			return hits;
		if (mode == MODE_UNCH) begin
			if (gcr[t][0] && clk12) begin
				prior = cnt_lo[t];
				c = {32'd0, cnt_lo[t]};
				p = {32'd0, prd_lo[t]};
				hits[0] = counter_advance(c, p, {32'd0, rel_lo[t]}, ena12);
				cnt_lo[t] = c[31:0];
				prd_lo[t] = p[31:0];
				if (cnt_lo[t] != prior && gcr[t][4])
					for (int n = 0; n < 8; n++)
						if (cmp[t][n] != 0 && cmp[t][n] == cnt_lo[t])
							hits[2+n] = 1'b1;
			end
			if (gcr[t][1] && ena34 != ENA_OFF) begin
				if (gcr[t][15:12] == gcr[t][11:8]) begin
					gcr[t][15:12] = 4'd0;
					c = {32'd0, cnt_hi[t]};
					p = {32'd0, prd_hi[t]};
					hits[1] = counter_advance(c, p, {32'd0, rel_hi[t]}, ena34);
					cnt_hi[t] = c[31:0];
					prd_hi[t] = p[31:0];
				end else
					gcr[t][15:12] = gcr[t][15:12] + 4'd1;
			end
			return hits;
		end
		if (gcr[t][1:0] != 2'b11 || !clk12 || ena12 == ENA_OFF)
			return hits;
		if (mode == MODE_CHAIN) begin
			if (cnt_hi[t] == prd_hi[t]) begin
				both = ena12 == ENA_RELOAD && prd_lo[t] != 0 && cnt_lo[t] == prd_lo[t];
				cnt_hi[t] = 0;
				c = {32'd0, cnt_lo[t]};
				p = {32'd0, prd_lo[t]};
				hits[0] = counter_advance(c, p, {32'd0, rel_lo[t]}, ena12);
				cnt_lo[t] = c[31:0];
				prd_lo[t] = p[31:0];
				if (both)
					prd_hi[t] = rel_hi[t];
			end else
				cnt_hi[t] = cnt_hi[t] + 1;
			return hits;
		end
		c = {cnt_hi[t], cnt_lo[t]};
		p = {prd_hi[t], prd_lo[t]};
		hits[0] = counter_advance(c, p, {rel_hi[t], rel_lo[t]}, ena12);
		{cnt_hi[t], cnt_lo[t]} = c;
		{prd_hi[t], prd_lo[t]} = p;
		return hits;
	endfunction

	function automatic bit decode_addr(logic [31:0] addr, output int t,
			output logic [11:0] off);
		logic [32:0] a;
		a = {1'b0, addr};
		t = 0;
		off = '0;
		if (a >= BASE_FIRST && a < {1'b0, BASE_FIRST} + 33'h1000) begin
			off = 12'(addr - BASE_FIRST);
			return 1;
		end
		if (a >= BASE_SECOND && a < {1'b0, BASE_SECOND} + 33'h1000) begin
			t = 1;
			off = 12'(addr - BASE_SECOND);
			return 1;
		end
		return 0;
	endfunction

	function automatic bit register_read(logic [31:0] addr, output logic [31:0] v);
		int          t;
		logic [11:0] off;
		bit          rr;
		v = '0;
		if (!decode_addr(addr, t, off) || off[1:0] != 2'b00)
			return 0;
		rr = gcr[t][4] && gcr[t][3:2] == MODE_UNCH;
		case (off)
			OFF_REV:   v = REVISION_WORD;
			OFF_EMU:   v = emu[t];
			OFF_GPEN:  v = gpen[t];
			OFF_GPDIR: v = gpdir[t];
			OFF_CNTLO: begin
				v = cnt_lo[t];
				if (gcr[t][3:2] == MODE_64) begin
					shadow_hi[t] = cnt_hi[t];
					shadow_ok[t] = 1;
				end else if (rr && tcr[t][10]) begin
					cap_lo[t] = cnt_lo[t];
					if (tcr[t][7:6] == ENA_RELOAD)
						prd_lo[t] = rel_lo[t];
					cnt_lo[t] = 0;
				end
			end
			OFF_CNTHI: begin
				v = shadow_ok[t] ? shadow_hi[t] : cnt_hi[t];
				shadow_ok[t] = 0;
				if (rr && tcr[t][26]) begin
					cap_hi[t] = cnt_hi[t];
					if (tcr[t][23:22] == ENA_RELOAD)
						prd_hi[t] = rel_hi[t];
					cnt_hi[t] = 0;
				end
			end
			OFF_PRDLO: v = prd_lo[t];
			OFF_PRDHI: v = prd_hi[t];
			OFF_TCR:   v = tcr[t];
			OFF_TGCR:  v = gcr[t];
			OFF_WDT:   v = wdt[t];
			OFF_RELLO: v = rel_lo[t];
			OFF_RELHI: v = rel_hi[t];
			OFF_CAPLO: v = cap_lo[t];
			OFF_CAPHI: v = cap_hi[t];
			OFF_ICS:   v = ics[t];
			default: begin
				if (off < OFF_CMP0 || off > OFF_CMPN)
					return 0;
				v = cmp[t][(off - OFF_CMP0) >> 2];
			end
		endcase
		return 1;
	endfunction

	function automatic bit register_write(logic [31:0] addr, logic [32:0] data,
			logic [3:0] size, logic go);
		int          t;
		logic [11:0] off;
		logic [31:0] w;
		if (!decode_addr(addr, t, off) || size != SIZE_WORD || data[32] ||
				off[1:0] != 2'b00 || off == OFF_REV)
			return 0;
		w = data[31:0];
		case (off)
			OFF_EMU:   if (go) emu[t] = w & 32'h3;
			OFF_GPEN:  if (go) gpen[t] = w & GPEN_WMASK;
			OFF_GPDIR: if (go) gpdir[t] = w & GPDIR_WMASK;
			OFF_CNTLO: if (go) cnt_lo[t] = w;
			OFF_CNTHI: if (go) begin
				cnt_hi[t] = w;
				shadow_ok[t] = 0;
			end
			OFF_PRDLO: if (go) prd_lo[t] = w;
			OFF_PRDHI: if (go) prd_hi[t] = w;
			OFF_TCR:   if (go) tcr[t] = w & TCR_WMASK;
			OFF_TGCR:  if (go) begin
				gcr[t] = w & TGCR_WMASK;
				if (gcr[t][3:2] != MODE_64)
					shadow_ok[t] = 0;
				if (!gcr[t][0])
					cnt_lo[t] = 0;
				if (!gcr[t][1]) begin
					cnt_hi[t] = 0;
					shadow_ok[t] = 0;
				end
			end
			OFF_WDT:   if (go)
				wdt[t] = (w & WDT_WMASK) | (w[15] ? 32'h0 : (wdt[t] & 32'h8000));
			OFF_RELLO: if (go) rel_lo[t] = w;
			OFF_RELHI: if (go) rel_hi[t] = w;
			OFF_CAPLO: if (go) cap_lo[t] = w;
			OFF_CAPHI: if (go) cap_hi[t] = w;
			OFF_ICS:   if (go)
				ics[t] = (ics[t] & ICS_STATUS & ~(w & ICS_STATUS)) | (w & ICS_ENABLES);
			default: begin
				if (off < OFF_CMP0 || off > OFF_CMPN)
					return 0;
				if (go)
					cmp[t][(off - OFF_CMP0) >> 2] = w;
			end
		endcase
		return 1;
	endfunction

	function automatic bus_result_t timer_apply(bus_item_t it);
		bus_result_t r;
		logic [9:0]  hits;
		r = '{default: '0};
		case (it.action)
			ACT_TICK: begin
				r.ok = 1'b1;
				for (int t = 0; t < 2; t++) begin
					if (gcr[t][1:0] == 2'b00)
						continue;
					hits = timer_tick(t);
					if (hits[0]) begin
						ics[t][1] = 1'b1;
						if (!ics[t][0])
							hits[0] = 1'b0;
					end
					if (hits[1]) begin
						ics[t][17] = 1'b1;
						if (!ics[t][16])
							hits[1] = 1'b0;
					end
					r.events[t*10 +: 10] = hits;
				end
			end
			ACT_READ:  r.ok = register_read(it.addr, r.rdata);
			ACT_WRITE: r.ok = register_write(it.addr, it.wdata, it.size, it.commit);
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
		errors++;
	endtask

	task automatic push(logic [1:0] act, logic [31:0] addr, logic [32:0] data = 0,
			logic [3:0] size = SIZE_WORD, logic commit = 1'b1, bit drain = 0);
		bus_item_t it;
		it = '{act, addr, data, size, commit, drain};
		pending_items.push_back(it);
	endtask

	function automatic logic [31:0] reg_addr(int t, logic [11:0] off);
		return (t == 0 ? BASE_FIRST : BASE_SECOND) + off;
	endfunction

	task automatic write_reg(int t, logic [11:0] off, logic [31:0] data);
		push(ACT_WRITE, reg_addr(t, off), {1'b0, data});
	endtask

	task automatic read_reg(int t, logic [11:0] off);
		push(ACT_READ, reg_addr(t, off));
	endtask

	task automatic ticks(int n);
		repeat (n) push(ACT_TICK, $urandom);
	endtask

	// program one timer with a random but well-formed setup
	task automatic setup_timer(int t);
		logic [31:0] g;
		write_reg(t, OFF_PRDLO, $urandom_range(0, 12));
		write_reg(t, OFF_PRDHI, $urandom_range(0, 3));
		write_reg(t, OFF_RELLO, $urandom_range(1, 12));
		write_reg(t, OFF_RELHI, $urandom_range(0, 3));
		write_reg(t, OFF_CMP0 + 12'(4 * $urandom_range(0, 7)), $urandom_range(0, 12));
		write_reg(t, OFF_ICS, $urandom);
		write_reg(t, OFF_TCR, ($urandom & 32'h04c00400) | ($urandom_range(0, 3) << 6) |
			($urandom_range(0, 3) << 22) | (($urandom_range(0, 9) == 0) << 8));
		g = 32'h3 | ($urandom_range(0, 3) << 2) | ($urandom_range(0, 1) << 4) |
			($urandom_range(0, 3) << 8);
		if ($urandom_range(0, 9) == 0)
			g[1:0] = 2'($urandom);
		write_reg(t, OFF_TGCR, g);
	endtask

	task automatic random_item();
		int          t, sel;
		logic [11:0] off;
		logic [32:0] data;
		t = $urandom_range(0, 1);
		off = 12'(4 * $urandom_range(0, 31));
		sel = $urandom_range(0, 99);
		if (sel < 50)
			ticks(1);
		else if (sel < 72)
			push(ACT_READ, $urandom_range(0, 19) == 0 ? $urandom : reg_addr(t, off) |
				($urandom_range(0, 19) == 0), $urandom);
		else if (sel < 95) begin
			data = $urandom_range(0, 3) == 0 ? {1'b0, $urandom} : 33'($urandom_range(0, 15));
			if (off == OFF_TGCR)
				data[1:0] = 2'b11;
			if ($urandom_range(0, 29) == 0)
				data[32] = 1'b1;
			push(ACT_WRITE, $urandom_range(0, 29) == 0 ? $urandom : reg_addr(t, off), data,
				$urandom_range(0, 14) == 0 ? 4'($urandom) : SIZE_WORD,
				$urandom_range(0, 9) != 0);
		end else
			push(ACT_BAD, $urandom, {1'b1, $urandom}, 4'($urandom), 1'($urandom));
	endtask

	always @(posedge clk or negedge arst_n) begin
		bus_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !s_tready) begin
		end else begin
			if (s_tvalid)
				expected_results.push_back(timer_apply(it));
			if (gap > 0) begin
				gap--;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() > 0 && (!pending_items[0].drain ||
					(expected_results.size() == 0 && !s_tvalid))) begin
				it = pending_items.pop_front();
				s_tdata <= {2'b00, it.commit, it.size, it.wdata, it.addr};
				s_tuser <= it.action;
				s_tvalid <= 1'b1;
				case ($urandom_range(0, 19))
					0: gap = $urandom_range(15, 50);
					1, 2, 3, 4, 5, 6: gap = $urandom_range(1, 3);
					default: gap = 0;
				endcase
			end else
				s_tvalid <= 1'b0;
		end
	end

	// m_tready is high for the first 150 results, then random, with one hold low after 300 results
	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;
		else if (!hold_done && results_seen >= 300) begin
			hold_cycles <= 400;
			hold_done <= 1;
		end
		if (hold_cycles > 1 || (!hold_done && results_seen >= 300))
			m_tready <= 1'b0;
		else
			m_tready <= results_seen < 150 ? 1'b1 : ($urandom_range(0, 39) == 0 ?
				1'b0 : $urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		bus_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0)
				report("unexpected result", m_tdata[31:0], 0);
			else begin
				want = expected_results.pop_front();
				if (m_tdata[31:0] !== want.rdata)
					report("read_data", m_tdata[31:0], want.rdata);
				if (m_tdata[32] !== want.ok)
					report("access_ok", m_tdata[32], want.ok);
				if (m_tdata[52:33] !== want.events)
					report("event_bits", m_tdata[52:33], want.events);
			end
		end
	end

	initial begin
		cnt_lo = '{default: '0}; cnt_hi = '{default: '0};
		prd_lo = '{default: '0}; prd_hi = '{default: '0};
		rel_lo = '{default: '0}; rel_hi = '{default: '0};
		cap_lo = '{default: '0}; cap_hi = '{default: '0};
		tcr = '{default: '0}; gcr = '{default: '0}; ics = '{default: '0};
		cmp = '{default: '{default: '0}};
		emu = '{default: '0}; gpen = '{default: '0}; gpdir = '{default: '0};
		wdt = '{default: '0}; shadow_hi = '{default: '0}; shadow_ok = '{default: 0};

		read_reg(0, OFF_REV);
		push(ACT_WRITE, reg_addr(1, OFF_REV), 33'h1);
		push(ACT_WRITE, reg_addr(0, OFF_PRDLO), 33'h1_0000_0003);
		push(ACT_WRITE, reg_addr(0, OFF_PRDLO), 33'h3, 4'd2);
		push(ACT_WRITE, reg_addr(0, OFF_PRDLO), 33'h3, SIZE_WORD, 1'b0);
		push(ACT_READ, reg_addr(0, OFF_TCR) + 2);
		push(ACT_READ, 32'hffff_fffc);
		push(ACT_BAD, reg_addr(0, OFF_REV), 33'h1_ffff_ffff, 4'hf, 1'b1);
		write_reg(0, OFF_PRDLO, 3);
		write_reg(0, OFF_CMP0 + 4, 2);
		write_reg(0, OFF_ICS, 32'hffff_ffff);
		write_reg(0, OFF_TCR, 32'hffff_ffff);
		write_reg(0, OFF_TCR, 32'h04c0_0480);
		write_reg(0, OFF_TGCR, 32'h0000_0117);
		ticks(6);
		read_reg(0, OFF_CNTLO);
		read_reg(0, OFF_CAPLO);
		write_reg(1, OFF_PRDLO, 32'hffff_ffff);
		write_reg(1, OFF_CNTLO, 32'hffff_fffe);
		write_reg(1, OFF_TCR, 32'h0000_0080);
		write_reg(1, OFF_TGCR, 32'h0000_0003);
		ticks(2);
		read_reg(1, OFF_CNTLO);
		read_reg(1, OFF_CNTHI);
		write_reg(0, OFF_WDT, 32'hffff_ffff);
		write_reg(0, OFF_EMU, 32'hffff_ffff);
		write_reg(0, OFF_GPEN, 32'hffff_ffff);
		write_reg(0, OFF_GPDIR, 32'hffff_ffff);
		write_reg(0, OFF_TGCR, 32'h0000_0008);

		for (int phase = 0; pending_items.size() < 950; phase++) begin
			setup_timer(phase % 2);
			if (phase % 3 == 0)
				setup_timer(1 - phase % 2);
			repeat ($urandom_range(15, 40))
				random_item();
			if (phase == 10)
				push(ACT_TICK, 0, 0, SIZE_WORD, 1'b1, 1);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_items.size() == 0 && !s_tvalid);
		wait (expected_results.size() == 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end
endmodule
